FILE: rtl/half_float_rgba_to_gamma_byte_assert.svh
// assertion macros for the half float to gamma byte converter
`ifndef HALF_FLOAT_RGBA_TO_GAMMA_BYTE_ASSERT_SVH
`define HALF_FLOAT_RGBA_TO_GAMMA_BYTE_ASSERT_SVH

// consequent checked in the same cycle as the trigger
`define HFRG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the trigger
`define HFRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hfrg_pkg.sv
// shared types, constants and gamma threshold table for the converter
package hfrg_pkg;

    localparam int HalfW     = 16;
    localparam int MagW      = 15;
    localparam int ByteW     = 8;
    localparam int ChW       = 2;
    localparam int NumLevels = 255;

    localparam logic [4:0]       ExpMax  = 5'h1f;
    localparam logic [4:0]       ExpOne  = 5'd15;
    localparam logic [4:0]       KBase   = 5'd25;
    localparam logic [4:0]       KSub    = 5'd24;
    localparam logic [MagW-1:0]  OneCode = 15'h3c00;
    localparam logic [ChW-1:0]   ChRed   = 2'd0;
    localparam logic [ChW-1:0]   ChAlpha = 2'd3;
    localparam logic [ByteW-1:0] ByteMax = 8'hff;

    typedef logic [NumLevels:1][MagW-1:0] t_thr_table;

    typedef struct packed {
        logic             valid;
        logic [HalfW-1:0] half;
        logic             last;
        logic [ChW-1:0]   ch;
    } t_item;

    typedef struct packed {
        logic [ByteW-1:0] pixel;
        logic [ChW-1:0]   ch;
        logic             last;
    } t_result;

    // exact test: 255 * v^(5/11) >= level for the positive code
    function automatic logic gamma_reaches(logic [HalfW-1:0] code, int level);
        logic [255:0] lhs;
        logic [255:0] rhs;
        logic [10:0]  m;
        int           k;
        int           i;
        if (code[14:10] == 5'd0) begin
            m = {1'b0, code[9:0]};
            k = 24;
        end else begin
            m = {1'b1, code[9:0]};
            k = 25 - int'(code[14:10]);
        end
        rhs = 256'd1;
        for (i = 0; i < 5; i++) rhs = rhs * 256'(m);
        for (i = 0; i < 11; i++) rhs = rhs * 256'd255;
        lhs = 256'd1;
        for (i = 0; i < 11; i++) lhs = lhs * 256'(level);
        lhs = lhs << (5 * k);
        return (lhs <= rhs);
    endfunction

    // smallest code whose gamma byte reaches each level, found by bisection
    function automatic t_thr_table build_thresholds();
        t_thr_table tbl;
        int         b;
        int         lo;
        int         hi;
        int         mid;
        for (b = 1; b <= NumLevels; b++) begin
            lo = 0;
            hi = int'(OneCode);
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (gamma_reaches(16'(mid), b)) hi = mid;
                else lo = mid + 1;
            end
            tbl[b] = MagW'(lo);
        end
        return tbl;
    endfunction

    localparam t_thr_table GammaThr = build_thresholds();

endpackage

FILE: rtl/hfrg_in_stage.sv
// input register and channel counter
module hfrg_in_stage import hfrg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [HalfW-1:0] i_half_value,
    input  logic             i_last_of_image,
    input  logic             i_out_ready,
    output logic             o_stall,
    output t_item            o_item,
    output logic [ChW-1:0]   o_counter
);

    t_item          r_item;
    t_item          n_item;
    logic [ChW-1:0] r_counter;
    logic [ChW-1:0] n_counter;
    logic           w_ready;
    logic           w_take;

    assign w_ready = !r_item.valid || i_out_ready;
    assign w_take  = i_valid && w_ready;

    always_comb begin
        n_item    = r_item;
        n_counter = r_counter;
        if (w_ready) begin
            n_item.valid = i_valid;
        end
        if (w_take) begin
            n_item.half = i_half_value;
            n_item.last = i_last_of_image;
            n_item.ch   = r_counter;
            // last word of an image restarts at red
            n_counter   = i_last_of_image ? ChRed : r_counter + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
            r_counter    <= ChRed;
        end else begin
            r_item.valid <= n_item.valid;
            r_counter    <= n_counter;
        end
        r_item.half <= n_item.half;
        r_item.last <= n_item.last;
        r_item.ch   <= n_item.ch;
    end

    assign o_stall   = !w_ready;
    assign o_item    = r_item;
    assign o_counter = r_counter;

endmodule

FILE: rtl/hfrg_convert.sv
// fp16 decode, clamp, gamma threshold bank and linear alpha scaling
module hfrg_convert import hfrg_pkg::*; (
    input  t_item   i_item,
    output t_result o_result
);

    logic                 w_sign;
    logic [4:0]           w_exp;
    logic [9:0]           w_frac;
    logic [MagW-1:0]      w_mag;
    logic                 w_nan;
    logic [NumLevels+1:0] w_ge;
    logic [ByteW-1:0]     w_gamma;
    logic [10:0]          w_m;
    logic [4:0]           w_k;
    logic [18:0]          w_prod;
    logic [ByteW-1:0]     w_alpha;

    assign w_sign = i_item.half[15];
    assign w_exp  = i_item.half[14:10];
    assign w_frac = i_item.half[9:0];
    assign w_mag  = i_item.half[14:0];
    assign w_nan  = (w_exp == ExpMax) && (w_frac != 10'd0);

    // thermometer of level crossings, the top crossing is the byte
    always_comb begin
        w_ge = '0;
        w_ge[0] = 1'b1;
        for (int b = 1; b <= NumLevels; b++) begin
            w_ge[b] = (w_mag >= GammaThr[b]);
        end
    end

    always_comb begin
        w_gamma = '0;
        for (int b = 1; b <= NumLevels; b++) begin
            if (w_ge[b] && !w_ge[b+1]) begin
                w_gamma = w_gamma | ByteW'(b);
            end
        end
    end

    // alpha: floor(255 * m / 2^k)
    assign w_m    = (w_exp == 5'd0) ? {1'b0, w_frac} : {1'b1, w_frac};
    assign w_k    = (w_exp == 5'd0) ? KSub : KBase - w_exp;
    assign w_prod = {w_m, 8'd0} - 19'(w_m);

    always_comb begin
        if (w_exp >= ExpOne) begin
            w_alpha = ByteMax;
        end else begin
            w_alpha = ByteW'(w_prod >> w_k);
        end
    end

    always_comb begin
        o_result.ch   = i_item.ch;
        o_result.last = i_item.last;
        if (w_nan || w_sign) begin
            o_result.pixel = '0;
        end else if (i_item.ch == ChAlpha) begin
            o_result.pixel = w_alpha;
        end else begin
            o_result.pixel = w_gamma;
        end
    end

endmodule

FILE: rtl/half_float_rgba_to_gamma_byte.sv
// top level: half float rgba component to 8-bit gamma encoded byte
//
// takes one binary16 component word per cycle and returns one byte word per
// cycle while the receiver does not stall. an accepted word sits in the
// input register, passes the conversion logic and lands in the result
// register when that register is empty or being drained, and its byte word
// then shows on the outputs. the rate of one word per cycle is set by
// the single-pass conversion: a bank of 255 constant compares of the 15-bit
// magnitude against gamma thresholds (exact floor of 255 * v^(1/2.2)) and a
// priority pick of the top crossing for red, green and blue, and a multiply
// by 255 with a right shift for alpha. negative values and nan give 0, values
// at or above one and +inf give 255. the channel index runs 0,1,2,3 and goes
// back to 0 after a word flagged last. while a result waits under stall the
// input register can still take one word, so the input side stalls only when
// both registers hold data and the output is stalled.
module half_float_rgba_to_gamma_byte import hfrg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [HalfW-1:0] i_half_value,
    input  logic             i_last_of_image,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ByteW-1:0] o_pixel_byte,
    output logic [ChW-1:0]   o_channel_index,
    output logic             o_last_out
);

`include "half_float_rgba_to_gamma_byte_assert.svh"

    t_item          w_item;
    t_result        w_result;
    logic [ChW-1:0] w_counter;
    logic           w_out_ready;

    logic    r_out_valid;
    t_result r_out;

    // terms for the checks below
    logic w_in_last;
    logic w_cnt_red;
    logic w_conv_neg;
    logic w_conv_sat;
    logic w_out_zero;
    logic w_out_max;

    // result register can load when empty or being drained
    assign w_out_ready = !r_out_valid || !i_stall;

    hfrg_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_half_value    (i_half_value),
        .i_last_of_image (i_last_of_image),
        .i_out_ready     (w_out_ready),
        .o_stall         (o_stall),
        .o_item          (w_item),
        .o_counter       (w_counter)
    );

    hfrg_convert u_convert (
        .i_item   (w_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_item.valid;
        end
        if (w_out_ready && w_item.valid) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_byte    = r_out.pixel;
    assign o_channel_index = r_out.ch;
    assign o_last_out      = r_out.last;

    assign w_in_last  = i_valid && !o_stall && i_last_of_image;
    assign w_cnt_red  = (w_counter == ChRed);
    assign w_conv_neg = w_item.valid && w_out_ready && w_item.half[15];
    assign w_conv_sat = w_item.valid && w_out_ready && !w_item.half[15] &&
                        (w_item.half[14:0] >= OneCode) && (w_item.half[14:0] <= 15'h7c00);
    assign w_out_zero = o_valid && (o_pixel_byte == '0);
    assign w_out_max  = o_valid && (o_pixel_byte == ByteMax);

    // a last word restarts the channel count
    `HFRG_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, w_in_last, w_cnt_red, "count not restarted")

    // negative inputs leave as zero
    `HFRG_ASSERT_NEXT(a_neg_zero, i_clk, i_rst_n, w_conv_neg, w_out_zero, "negative not zero")

    // one and above, including +inf, saturate
    `HFRG_ASSERT_NEXT(a_sat_one, i_clk, i_rst_n, w_conv_sat, w_out_max, "no saturation at one")

endmodule

FILE: test/tb_half_float_rgba_to_gamma_byte.sv
// testbench for the half float rgba to gamma byte converter
module tb_half_float_rgba_to_gamma_byte;
    import hfrg_pkg::*;

    // run shape
    localparam int TotalWords  = 1750;
    localparam int IdlePct     = 26;
    localparam int QuietLo     = 700;   // no idling on either side in this window
    localparam int QuietHi     = 1000;
    localparam int HoldAt      = 400;   // results seen before the long receiver hold
    localparam int HoldCycles  = 64;
    localparam int DrainCycles = 8;     // two-stage pipe, plenty of margin
    localparam int WatchLimit  = 2000;

    // per-word expected result and running channel position
    class pixel_scoreboard;
        t_result          pending_q[$];
        logic [ChW-1:0]   chan = ChRed;
        int               noted = 0;
        int               checked = 0;
        int               errors = 0;
        int               alpha_words = 0;
        int               last_words = 0;
        int               special_words = 0;

        // work out the byte for one accepted component and queue it
        function void note_word(logic [HalfW-1:0] half, logic lst);
            t_result          want;
            logic [4:0]       ex;
            logic [9:0]       frac;
            logic [10:0]      mant;
            int               shift;
            logic [255:0]     target;
            logic [255:0]     probe;
            int               lo;
            int               hi;
            int               mid;
            int               i;
            ex   = half[14:10];
            frac = half[9:0];
            want.ch   = chan;
            want.last = lst;
            if ((ex == ExpMax && frac != 0) || half[15]) begin
                // nan, negative and negative zero all land on zero
                want.pixel = '0;
                special_words++;
            end else if (ex >= ExpOne) begin
                // one and above, +inf saturate
                want.pixel = ByteMax;
                special_words++;
            end else if (ex == 0 && frac == 0) begin
                want.pixel = '0;
            end else begin
                // value is mant / 2^shift exactly
                if (ex == 0) begin
                    mant  = {1'b0, frac};
                    shift = 24;
                end else begin
                    mant  = {1'b1, frac};
                    shift = 25 - int'(ex);
                end
                if (chan == ChAlpha) begin
                    want.pixel = ByteW'((32'd255 * mant) >> shift);
                end else begin
                    // largest b with b^11 * 2^(5*shift) <= mant^5 * 255^11
                    target = 256'd1;
                    for (i = 0; i < 5; i++) target = target * 256'(mant);
                    for (i = 0; i < 11; i++) target = target * 256'd255;
                    lo = 0;
                    hi = 255;
                    while (lo < hi) begin
                        mid   = (lo + hi + 1) / 2;
                        probe = 256'd1;
                        for (i = 0; i < 11; i++) probe = probe * 256'(mid);
                        probe = probe << (5 * shift);
                        if (probe <= target) lo = mid;
                        else hi = mid - 1;
                    end
                    want.pixel = ByteW'(lo);
                end
            end
            if (chan == ChAlpha) alpha_words++;
            if (lst) last_words++;
            pending_q = {pending_q, want};
            noted++;
            chan = lst ? ChRed : ChW'(chan + 1'b1);
        endfunction

        // compare one accepted byte word with the oldest expectation
        function void check_word(logic [ByteW-1:0] pixel, logic [ChW-1:0] ch, logic lst);
            t_result want;
            checked++;
            if (pending_q.size() == 0) begin
                errors++;
                $error("byte word arrived with nothing outstanding");
                return;
            end
            want = pending_q.pop_front();
            if (pixel !== want.pixel) begin
                errors++;
                $error("pixel_byte: expected %0d, got %0d", want.pixel, pixel);
            end
            if (ch !== want.ch) begin
                errors++;
                $error("channel_index: expected %0d, got %0d", want.ch, ch);
            end
            if (lst !== want.last) begin
                errors++;
                $error("last_out: expected %0d, got %0d", want.last, lst);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [HalfW-1:0] i_half_value = '0;
    logic             i_last_of_image = 1'b0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [ByteW-1:0] o_pixel_byte;
    logic [ChW-1:0]   o_channel_index;
    logic             o_last_out;

    pixel_scoreboard sb = new;
    bit              long_hold_done = 1'b0;
    int              idle_cycles = 0;

    half_float_rgba_to_gamma_byte u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_half_value    (i_half_value),
        .i_last_of_image (i_last_of_image),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_byte    (o_pixel_byte),
        .o_channel_index (o_channel_index),
        .o_last_out      (o_last_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // offer one component word, holding it until the block takes it;
    // handshakes are judged at the falling edge where everything is settled
    task automatic send_word(input logic [HalfW-1:0] half, input logic lst);
        if (!(sb.noted >= QuietLo && sb.noted < QuietHi) &&
            $urandom_range(0, 99) < IdlePct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IdlePct);
        end
        i_valid         <= 1'b1;
        i_half_value    <= half;
        i_last_of_image <= lst;
        do @(negedge i_clk); while (o_stall !== 1'b0);
        sb.note_word(half, lst);
        @(posedge i_clk);
    endtask

    // directed words: {last, half}
    task automatic run_directed();
        logic [HalfW:0] seq [26] = '{
            17'h0_0000,  // zero on red
            17'h0_0001,  // smallest subnormal, color curve
            17'h0_03ff,  // largest subnormal
            17'h0_3bff,  // just below one on alpha, counter wraps with no last
            17'h0_3c00,  // exactly one
            17'h0_7c00,  // +inf
            17'h0_7e00,  // quiet nan
            17'h0_0001,  // smallest subnormal on alpha floors to zero
            17'h0_8000,  // negative zero
            17'h0_fc00,  // -inf
            17'h0_ffff,  // negative nan
            17'h1_3800,  // half on alpha, last at alpha
            17'h1_3bff,  // last on red: counter stays at red
            17'h0_0400,  // smallest normal
            17'h1_7bff,  // largest finite, last on green
            17'h0_3555,
            17'h0_bc00,  // minus one
            17'h1_7c01,  // signaling nan, last on blue
            17'h0_2e66,
            17'h0_1234,
            17'h0_3c01,  // just above one
            17'h0_7c00,  // +inf on alpha
            17'h0_fc00,
            17'h0_03ff,
            17'h0_7e00,
            17'h1_ffff   // nan on alpha with last
        };
        foreach (seq[n]) send_word(seq[n][HalfW-1:0], seq[n][HalfW]);
    endtask

    // random words: mostly in-range magnitudes, some subnormals, rest anything;
    // last mostly closes an rgba group but can cut one short too
    task automatic run_random();
        logic [HalfW-1:0] half;
        logic             lst;
        int               pick;
        while (sb.noted < TotalWords) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) half = {1'b0, 15'($urandom_range(0, int'(OneCode) - 1))};
            else if (pick < 65) half = {6'b0, 10'($urandom)};
            else half = HalfW'($urandom);
            if (sb.chan == ChAlpha) lst = ($urandom_range(0, 5) == 0);
            else lst = ($urandom_range(0, 39) == 0);
            send_word(half, lst);
        end
    endtask

    // receiver stall: random idling, a quiet window, and one long hold that
    // lets the pipe fill and back up onto the input side
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && sb.checked >= HoldAt) begin
                long_hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
            end else if (sb.checked >= QuietLo && sb.checked < QuietHi) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IdlePct);
            end
        end
    end

    // result monitor, sampled at the falling edge ahead of the accepting edge
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                sb.check_word(o_pixel_byte, o_channel_index, o_last_out);
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchLimit) begin
                $display("timeout: %0d words still outstanding", sb.pending_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("sent %0d components (%0d alpha, %0d flagged last, %0d nan/negative/saturated)",
                 sb.noted, sb.alpha_words, sb.last_words, sb.special_words);
        $display("checked %0d byte words, including one long output hold with input backpressure",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hfrg_pkg.sv
rtl/hfrg_in_stage.sv
rtl/hfrg_convert.sv
rtl/half_float_rgba_to_gamma_byte.sv
test/tb_half_float_rgba_to_gamma_byte.sv
